/* design/sqot_pkg.sv */
// Shared types, constants and arithmetic helpers for the segment and quad overlap test.
package sqot_pkg;

   localparam int COORD_BITS = 16;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int CROSS_BITS = PROD_BITS + 1;
   localparam int SUM_BITS   = CROSS_BITS + 2;

   localparam int NUM_REGS      = 8;
   localparam int REG_IDX_BITS  = $clog2(NUM_REGS);
   localparam int CSR_ADDR_BITS = REG_IDX_BITS + 2;
   localparam int CSR_DATA_BITS = 32;

   localparam int REQ_DATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = 8;

   localparam logic [REG_IDX_BITS-1:0] REG_CORNER1_X = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_CORNER1_Y = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_CORNER2_X = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_CORNER2_Y = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_CORNER3_X = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_CORNER3_Y = 3'd5;
   localparam logic [REG_IDX_BITS-1:0] REG_CORNER4_X = 3'd6;
   localparam logic [REG_IDX_BITS-1:0] REG_CORNER4_Y = 3'd7;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [CROSS_BITS-1:0] cross_type;
   typedef logic [CROSS_BITS-1:0]        mag_type;
   typedef logic [SUM_BITS-1:0]          sum_type;

   typedef struct packed {
      coord_type y;
      coord_type x;
   } point_type;

   typedef point_type [3:0] quad_type;

   typedef struct packed {
      point_type end_pt;
      point_type start_pt;
   } seg_type;

   // A cross product held as its two terms: value is a minus b.
   typedef struct packed {
      prod_type a;
      prod_type b;
   } pair_type;

   typedef struct packed {
      pair_type [1:0][3:0] tris;
      pair_type [1:0]      area;
      pair_type [3:0]      d;
      pair_type [3:0]      u;
      pair_type [3:0]      v;
   } prods_type;

   function automatic diff_type diff_of(coord_type p, coord_type q);
      diff_of = diff_type'(p) - diff_type'(q);
   endfunction

   function automatic prod_type mul_of(diff_type p, diff_type q);
      mul_of = prod_type'(p) * prod_type'(q);
   endfunction

   function automatic cross_type cross_of(pair_type t);
      cross_of = cross_type'(t.a) - cross_type'(t.b);
   endfunction

   function automatic mag_type mag_of(pair_type t);
      cross_type c;
      c = cross_of(t);
      mag_of = c[CROSS_BITS-1] ? mag_type'(-c) : mag_type'(c);
   endfunction

endpackage

/* design/sqot_csr.sv */
// Configuration register file holding the four quad corners.
module sqot_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [sqot_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [sqot_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [sqot_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready,
   output sqot_pkg::quad_type                   quad
);
   import sqot_pkg::*;

   coord_type                regs_ff [NUM_REGS];
   logic [REG_IDX_BITS-1:0]  idx;
   logic                     wr_en;

   assign idx        = csr_paddr[CSR_ADDR_BITS-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
      end else if (wr_en) begin
         regs_ff[idx] <= csr_pwdata[COORD_BITS-1:0];
      end
   end

   assign csr_prdata = CSR_DATA_BITS'(regs_ff[idx]);

   always_comb begin
      quad[0].x = regs_ff[REG_CORNER1_X];
      quad[0].y = regs_ff[REG_CORNER1_Y];
      quad[1].x = regs_ff[REG_CORNER2_X];
      quad[1].y = regs_ff[REG_CORNER2_Y];
      quad[2].x = regs_ff[REG_CORNER3_X];
      quad[2].y = regs_ff[REG_CORNER3_Y];
      quad[3].x = regs_ff[REG_CORNER4_X];
      quad[3].y = regs_ff[REG_CORNER4_Y];
   end

endmodule

/* design/sqot_prod.sv */
// Difference and product stage: forms every cross-product term for one segment.
module sqot_prod (
   input  sqot_pkg::seg_type   seg,
   input  sqot_pkg::quad_type  quad,
   output sqot_pkg::prods_type prods
);
   import sqot_pkg::*;

   point_type pt [2];
   diff_type  dx1, dy1;

   assign pt[0] = seg.start_pt;
   assign pt[1] = seg.end_pt;
   assign dx1   = diff_of(seg.end_pt.x, seg.start_pt.x);
   assign dy1   = diff_of(seg.end_pt.y, seg.start_pt.y);

   always_comb begin
      point_type q, r;
      diff_type  dx2, dy2, ox, oy;
      for (int p = 0; p < 2; p++) begin
         for (int e = 0; e < 4; e++) begin
            q = quad[e];
            r = quad[2'(e + 1)];
            prods.tris[p][e].a = mul_of(diff_of(q.x, pt[p].x), diff_of(r.y, pt[p].y));
            prods.tris[p][e].b = mul_of(diff_of(q.y, pt[p].y), diff_of(r.x, pt[p].x));
         end
      end
      for (int k = 0; k < 2; k++) begin
         q = quad[2'(k + 1)];
         r = quad[2'(k + 2)];
         prods.area[k].a = mul_of(diff_of(q.x, quad[0].x), diff_of(r.y, quad[0].y));
         prods.area[k].b = mul_of(diff_of(q.y, quad[0].y), diff_of(r.x, quad[0].x));
      end
      for (int e = 0; e < 4; e++) begin
         q   = quad[e];
         r   = quad[2'(e + 1)];
         dx2 = diff_of(r.x, q.x);
         dy2 = diff_of(r.y, q.y);
         ox  = diff_of(q.x, seg.start_pt.x);
         oy  = diff_of(q.y, seg.start_pt.y);
         prods.d[e].a = mul_of(dx1, dy2);
         prods.d[e].b = mul_of(dy1, dx2);
         prods.u[e].a = mul_of(ox, dy2);
         prods.u[e].b = mul_of(oy, dx2);
         prods.v[e].a = mul_of(ox, dy1);
         prods.v[e].b = mul_of(oy, dx1);
      end
   end

endmodule

/* design/sqot_eval.sv */
// Decision stage: area sums for the inside test and range checks for the edge crossings.
module sqot_eval (
   input  sqot_pkg::prods_type prods,
   output logic                hit
);
   import sqot_pkg::*;

   logic [1:0] in_quad;
   logic [3:0] crossed;
   sum_type    quad_sum;

   assign quad_sum = sum_type'(mag_of(prods.area[0])) + sum_type'(mag_of(prods.area[1]));

   always_comb begin
      sum_type pt_sum;
      for (int p = 0; p < 2; p++) begin
         pt_sum = '0;
         for (int e = 0; e < 4; e++) begin
            pt_sum = pt_sum + sum_type'(mag_of(prods.tris[p][e]));
         end
         in_quad[p] = (pt_sum <= quad_sum);
      end
   end

   always_comb begin
      cross_type d, u, v;
      for (int e = 0; e < 4; e++) begin
         d = cross_of(prods.d[e]);
         u = cross_of(prods.u[e]);
         v = cross_of(prods.v[e]);
         if (d > 0) begin
            crossed[e] = (u >= 0) && (u <= d) && (v >= 0) && (v <= d);
         end else if (d < 0) begin
            crossed[e] = (u <= 0) && (u >= d) && (v <= 0) && (v >= d);
         end else begin
            crossed[e] = 1'b0;
         end
      end
   end

   assign hit = (|in_quad) || (|crossed);

endmodule

/* design/segment_quad_overlap_test.sv */
// Top level of the segment and quad overlap test: stream ports, pipeline registers and CSRs.
//
//   Port group   Direction   Word contents
//   req_*        in          one segment: start_x, start_y, end_x, end_y
//   rsp_*        out         one result: hit
//   csr_*        in/out      eight corner coordinate registers
//
// Each word passes an input register, a product register and a result register, in that
// order, and its result is offered from the result register; one word is taken every
// cycle while the result is not stalled.
// The products come from 17 by 17 bit multipliers, which are combinational.
// Reset empties the pipeline and clears all corners to zero.
// A stalled result holds the whole pipeline; req_tready follows rsp_tready in that case.
module segment_quad_overlap_test (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // start_x, start_y, end_x, end_y from the lowest bit up
   input  logic [sqot_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // hit in bit 0, zeros above
   output logic [sqot_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [sqot_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [sqot_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [sqot_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);
   import sqot_pkg::*;

   quad_type  quad;
   logic      advance;
   seg_type   seg_in;
   prods_type prods_in;
   logic      hit_in;

   logic      s1_valid_ff;
   seg_type   s1_seg_ff;
   logic      s2_valid_ff;
   prods_type s2_prods_ff;
   logic      rsp_valid_ff;
   logic      hit_ff;

   sqot_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .quad        (quad)
   );

   sqot_prod u_prod (
      .seg   (s1_seg_ff),
      .quad  (quad),
      .prods (prods_in)
   );

   sqot_eval u_eval (
      .prods (s2_prods_ff),
      .hit   (hit_in)
   );

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      seg_in.start_pt.x = req_tdata[COORD_BITS-1:0];
      seg_in.start_pt.y = req_tdata[2*COORD_BITS-1:COORD_BITS];
      seg_in.end_pt.x   = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
      seg_in.end_pt.y   = req_tdata[4*COORD_BITS-1:3*COORD_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_tvalid;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_seg_ff   <= seg_in;
         s2_prods_ff <= prods_in;
         hit_ff      <= hit_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(hit_ff);

   a_stage_to_rsp : assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && advance) |=> rsp_tvalid)
      else $error("Product stage word did not reach the result register.");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      (!advance) |=> ($stable(s1_valid_ff) && $stable(s2_valid_ff)))
      else $error("Pipeline moved while the result was stalled.");

   a_accept_moves : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> s1_valid_ff)
      else $error("Accepted word did not enter the input register.");

endmodule

/* tb/segment_quad_overlap_test_tb.sv */
// Self-checking testbench for the segment and quad overlap test, with a predictor and random traffic.
module segment_quad_overlap_test_tb;
   import sqot_pkg::*;

   localparam int PIPE_DEPTH  = 3;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 400000;
   localparam int ROUNDS      = 8;
   localparam int ROUND_WORDS = 190;
   localparam int PRESS_WORDS = 80;
   localparam int COORD_MAX   = 2 ** (COORD_BITS - 1) - 1;
   localparam int COORD_MIN   = -COORD_MAX - 1;

   typedef enum {QUAD_RECT, QUAD_JITTER, QUAD_ANY, QUAD_EXTREME} quad_kind_type;

   localparam logic [REG_IDX_BITS-1:0] CORNER_REGS [NUM_REGS] = '{
      REG_CORNER1_X, REG_CORNER1_Y, REG_CORNER2_X, REG_CORNER2_Y,
      REG_CORNER3_X, REG_CORNER3_Y, REG_CORNER4_X, REG_CORNER4_Y};
   localparam quad_kind_type ROUND_KIND [ROUNDS] = '{
      QUAD_EXTREME, QUAD_RECT, QUAD_JITTER, QUAD_ANY,
      QUAD_RECT, QUAD_ANY, QUAD_JITTER, QUAD_RECT};
   localparam int ROUND_SPAN [ROUNDS] = '{32767, 64, 300, 8000, 16, 32767, 2048, 300};
   localparam int SEND_IDLE [4]  = '{0, 77, 0, 10};
   localparam int RECV_STALL [4] = '{0, 0, 77, 10};

   class overlap_scoreboard;
      bit signed [COORD_BITS-1:0] corner_x [4];
      bit signed [COORD_BITS-1:0] corner_y [4];
      bit pending_hits [$];
      int checked;
      int hits;
      int mismatches;

      function void load_register(logic [REG_IDX_BITS-1:0] idx,
                                  logic [CSR_DATA_BITS-1:0] word);
         if (idx[0])
            corner_y[idx[REG_IDX_BITS-1:1]] = word[COORD_BITS-1:0];
         else
            corner_x[idx[REG_IDX_BITS-1:1]] = word[COORD_BITS-1:0];
      endfunction

      function longint area2(longint ax, longint ay, longint bx, longint by,
                             longint cx, longint cy);
         longint t;
         t = ax * (by - cy) + bx * (cy - ay) + cx * (ay - by);
         return (t < 0) ? -t : t;
      endfunction

      // Boundary points count as inside, so the comparison is not strict.
      function bit point_inside(longint px, longint py);
         longint quad_area;
         longint fan;
         quad_area = area2(corner_x[0], corner_y[0], corner_x[1], corner_y[1],
                           corner_x[2], corner_y[2]) +
                     area2(corner_x[0], corner_y[0], corner_x[2], corner_y[2],
                           corner_x[3], corner_y[3]);
         fan = 0;
         for (int i = 0; i < 4; i++)
            fan += area2(px, py, corner_x[i], corner_y[i],
                         corner_x[(i + 1) % 4], corner_y[(i + 1) % 4]);
         return fan <= quad_area;
      endfunction

      function bit edge_crossed(longint ax, longint ay, longint bx, longint by,
                                longint qx, longint qy, longint rx, longint ry);
         longint den;
         longint u;
         longint v;
         den = (bx - ax) * (ry - qy) - (by - ay) * (rx - qx);
         u = (qx - ax) * (ry - qy) - (qy - ay) * (rx - qx);
         v = (qx - ax) * (by - ay) - (qy - ay) * (bx - ax);
         if (den > 0)
            return u >= 0 && u <= den && v >= 0 && v <= den;
         if (den < 0)
            return u <= 0 && u >= den && v <= 0 && v >= den;
         return 1'b0;
      endfunction

      function bit predict_hit(seg_type s);
         longint ax;
         longint ay;
         longint bx;
         longint by;
         bit hit;
         ax = s.start_pt.x;
         ay = s.start_pt.y;
         bx = s.end_pt.x;
         by = s.end_pt.y;
         hit = point_inside(ax, ay) || point_inside(bx, by);
         for (int i = 0; i < 4 && !hit; i++)
            hit = edge_crossed(ax, ay, bx, by, corner_x[i], corner_y[i],
                               corner_x[(i + 1) % 4], corner_y[(i + 1) % 4]);
         return hit;
      endfunction

      function void note_segment(seg_type s);
         pending_hits.push_back(predict_hit(s));
      endfunction

      function void check_hit(logic hit);
         bit want;
         if (pending_hits.size() == 0) begin
            $error("hit: expected no word, got %0d", hit);
            mismatches++;
         end else begin
            want = pending_hits.pop_front();
            checked++;
            if (want)
               hits++;
            if (hit !== want) begin
               $error("hit: expected %0d, got %0d", want, hit);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // start_x, start_y, end_x, end_y from the lowest bit up
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // hit in bit 0, zeros above
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   overlap_scoreboard sb;
   int  idle_pct = 0;
   int  stall_pct = 0;
   bit  hold_request = 1'b0;
   int  cycle_count = 0;
   int  quads_loaded = 0;
   int  quad_c [8] = '{default: 0};

   segment_quad_overlap_test dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Both handshakes are observed in one process so that a word is always noted before its result.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_segment(seg_type'(req_tdata));
         if (rsp_tvalid && rsp_tready)
            sb.check_hit(rsp_tdata[0]);
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic coord_type to_coord(int v);
      if (v > COORD_MAX)
         v = COORD_MAX;
      if (v < COORD_MIN)
         v = COORD_MIN;
      return coord_type'(v);
   endfunction

   function automatic int rand_coord(int span);
      return int'($urandom_range(2 * span)) - span;
   endfunction

   function automatic int extreme_coord();
      case ($urandom_range(3))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2: return 0;
         default: return -1;
      endcase
   endfunction

   function automatic seg_type rand_segment(int span);
      int r;
      int k;
      int sgn;
      int reach;
      int a [4];
      seg_type s;
      r = $urandom_range(99);
      reach = span + span / 2;
      for (int i = 0; i < 4; i++)
         a[i] = rand_coord(reach);
      if (r < 8) begin
         for (int i = 0; i < 4; i++)
            a[i] = int'($urandom_range(2 ** COORD_BITS - 1)) + COORD_MIN;
      end else if (r < 16) begin
         a[2] = a[0];
         a[3] = a[1];
      end else if (r < 22) begin
         for (int i = 0; i < 4; i++)
            a[i] = extreme_coord();
      end else if (r < 32) begin
         // A segment parallel to one side of the quad.
         k = $urandom_range(3);
         sgn = $urandom_range(1) ? 1 : -1;
         a[2] = a[0] + sgn * (quad_c[2 * ((k + 1) % 4)] - quad_c[2 * k]);
         a[3] = a[1] + sgn * (quad_c[2 * ((k + 1) % 4) + 1] - quad_c[2 * k + 1]);
      end else if (r < 40) begin
         k = $urandom_range(3);
         a[0] = quad_c[2 * k];
         a[1] = quad_c[2 * k + 1];
      end
      s.start_pt.x = to_coord(a[0]);
      s.start_pt.y = to_coord(a[1]);
      s.end_pt.x   = to_coord(a[2]);
      s.end_pt.y   = to_coord(a[3]);
      return s;
   endfunction

   task automatic send_segment(seg_type s);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   task automatic send_xy(int ax, int ay, int bx, int by);
      seg_type s;
      s.start_pt.x = to_coord(ax);
      s.start_pt.y = to_coord(ay);
      s.end_pt.x   = to_coord(bx);
      s.end_pt.y   = to_coord(by);
      send_segment(s);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_hits.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_register(logic [REG_IDX_BITS-1:0] idx, int value);
      logic [CSR_DATA_BITS-1:0] word;
      word = $urandom;
      word[COORD_BITS-1:0] = value[COORD_BITS-1:0];
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      sb.load_register(idx, word);
   endtask

   task automatic set_quad();
      wait_for_results();
      repeat (PIPE_DEPTH + 2) @(posedge clock);
      for (int i = 0; i < NUM_REGS; i++)
         write_register(CORNER_REGS[i], quad_c[i]);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      quads_loaded++;
   endtask

   task automatic build_quad(quad_kind_type kind, int span);
      int x0;
      int x1;
      int y0;
      int y1;
      int t;
      x0 = rand_coord(span);
      x1 = rand_coord(span);
      y0 = rand_coord(span);
      y1 = rand_coord(span);
      if (x0 > x1) begin
         t = x0;
         x0 = x1;
         x1 = t;
      end
      if (y0 > y1) begin
         t = y0;
         y0 = y1;
         y1 = t;
      end
      quad_c = '{x0, y1, x1, y1, x1, y0, x0, y0};
      for (int i = 0; i < 8; i++) begin
         case (kind)
            QUAD_JITTER: quad_c[i] = to_coord(quad_c[i] + rand_coord(span / 4));
            QUAD_ANY: quad_c[i] = rand_coord(span);
            QUAD_EXTREME: quad_c[i] = $urandom_range(1) ? COORD_MAX : COORD_MIN;
            default: ;
         endcase
      end
   endtask

   initial begin
      sb = new;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With every corner at zero the quad collapses to a point and swallows everything.
      send_xy(0, 0, 0, 0);
      send_xy(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);

      quad_c = '{-100, 100, 100, 100, 100, -100, -100, -100};
      set_quad();
      send_xy(0, 0, 5, 5);
      send_xy(0, 0, 500, 0);
      send_xy(-500, 0, 500, 0);
      send_xy(-500, 500, 500, 600);
      send_xy(100, 100, 300, 300);
      send_xy(-200, 100, 200, 100);
      send_xy(-50, 100, -50, 300);
      send_xy(-300, -100, -150, -100);
      send_xy(50, 50, 50, 50);
      send_xy(150, 0, 150, 0);
      send_xy(-101, 0, -101, 500);
      send_xy(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
      send_xy(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);

      // A self-crossing bow tie.
      quad_c = '{-1000, 1000, 1000, -1000, 1000, 1000, -1000, -1000};
      set_quad();
      send_xy(0, 500, 0, 500);
      send_xy(-500, 0, -500, 0);
      send_xy(-2000, 0, 2000, 0);

      quad_c = '{COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                 COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN};
      set_quad();
      send_xy(0, 0, 0, 0);
      send_xy(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
      send_xy(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN);

      // All four corners on one line.
      quad_c = '{-1000, -1000, 0, 0, 1000, 1000, 500, 500};
      set_quad();
      send_xy(0, 0, 0, 0);
      send_xy(-500, 500, 500, -500);
      send_xy(2000, 2000, 3000, 3000);

      for (int round = 0; round < ROUNDS; round++) begin
         build_quad(ROUND_KIND[round], ROUND_SPAN[round]);
         set_quad();
         idle_pct  = SEND_IDLE[round % 4];
         stall_pct = RECV_STALL[round % 4];
         for (int n = 0; n < ROUND_WORDS; n++)
            send_segment(rand_segment(ROUND_SPAN[round]));
         if (round == 3) begin
            // The receiver stops for a long stretch while words keep coming.
            wait_for_results();
            idle_pct = 0;
            hold_request = 1'b1;
            for (int n = 0; n < PRESS_WORDS; n++)
               send_segment(rand_segment(ROUND_SPAN[round]));
            wait_for_results();
         end
      end

      wait_for_results();
      repeat (PIPE_DEPTH + 4) @(posedge clock);
      $display("Checked %0d segment words, %0d of them hits, over %0d corner settings.",
               sb.checked, sb.hits, quads_loaded);
      $display("Traffic ran under four idling mixes and one %0d-cycle receiver hold-off.",
               HOLD_CYCLES);
      if (sb.mismatches == 0 && sb.pending_hits.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
